/* design/ts_packetizer_core_defines.svh */
// ----------------------------------------------------------------------------
// ts_packetizer_core_defines.svh
// Assertion macros shared by the transport stream packetizer.
// ----------------------------------------------------------------------------
`ifndef TS_PACKETIZER_CORE_DEFINES_SVH
`define TS_PACKETIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ts_pkt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkt_pkg
// Types, constants and codes shared by the packetizer modules.
// ----------------------------------------------------------------------------
package ts_pkt_pkg;

  localparam int unsigned LenW = 21;
  localparam int unsigned PcrW = 33;
  localparam int unsigned PidW = 13;
  localparam int unsigned CcW  = 4;
  localparam int unsigned ChW  = 2;

  localparam int unsigned MaxUnitBytesDef = 1048576;
  localparam int unsigned QueueDepthDef   = 4;

  localparam logic [7:0] SyncByte    = 8'h47;
  localparam logic [7:0] PktPayload  = 8'd184;
  localparam logic [7:0] PcrRoom     = 8'd176;
  localparam logic [7:0] StuffByte   = 8'hFF;
  localparam logic [7:0] PcrFlags    = 8'h10;
  localparam logic [7:0] NoFlags     = 8'h00;
  localparam logic [7:0] PcrExt      = 8'h00;
  localparam logic [6:0] PcrTail     = 7'h7E;
  localparam logic [3:0] CtrlPayload = 4'h1;
  localparam logic [3:0] CtrlAdapt   = 4'h3;
  localparam logic [7:0] AdaptNoPcr  = 8'd2;
  localparam logic [7:0] AdaptPcr    = 8'd8;

  typedef enum logic [1:0] {
    REG_PID_PAT   = 2'd0,
    REG_PID_PMT   = 2'd1,
    REG_PID_VIDEO = 2'd2,
    REG_PID_AUDIO = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            we;
    cfg_reg_t        index;
    logic [PidW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            unit_start;
    logic [LenW-1:0] unit_length;
    logic [ChW-1:0]  channel;
    logic            pcr_present;
    logic [PcrW-1:0] pcr_base;
  } in_item_t;

  // One classified beat: the data byte plus what its header must carry.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            pkt_end;
    logic            hdr;
    logic            first;
    logic            pcr;
    logic [PcrW-1:0] pcr_base;
    logic [PidW-1:0] pid;
    logic [CcW-1:0]  cc;
    logic [7:0]      adapt;
  } job_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       packet_end;
    logic       last_of_run;
  } result_t;

  typedef enum logic [3:0] {
    STEP_SYNC,
    STEP_PID_HI,
    STEP_PID_LO,
    STEP_CTRL,
    STEP_ADAPT_LEN,
    STEP_FLAGS,
    STEP_PCR0,
    STEP_PCR1,
    STEP_PCR2,
    STEP_PCR3,
    STEP_PCR4,
    STEP_PCR5,
    STEP_STUFF,
    STEP_DATA
  } step_t;

endpackage

/* design/ts_pkt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkt_front
// Tracks unit and packet position, PIDs and continuity counters; turns each
// accepted beat of an open unit into one job for the back end.
// ----------------------------------------------------------------------------
module ts_pkt_front
  import ts_pkt_pkg::*;
#(
  parameter int unsigned MAX_UNIT_BYTES = MaxUnitBytesDef
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  logic     full,
  output logic     push,
  output job_t     job
);

  localparam int unsigned MaxW = $clog2(MAX_UNIT_BYTES + 1);
  localparam int unsigned CmpW = (MaxW > LenW) ? MaxW : LenW;

  logic [PidW-1:0] pid_reg [4];
  logic [CcW-1:0]  cc_reg  [4];
  logic [LenW-1:0] unit_bytes_left;
  logic [7:0]      packet_bytes_left;
  logic [ChW-1:0]  current_channel;
  logic            unit_open;

  logic            fire;
  logic            open_eff;
  logic            need_hdr;
  logic            use_pcr;
  logic [LenW-1:0] len_fix;
  logic [LenW-1:0] len_eff;
  logic [ChW-1:0]  ch_eff;
  logic [7:0]      room;
  logic [7:0]      data_cnt;
  logic [7:0]      pbl_next;
  logic [LenW-1:0] ubl_next;

  always_comb begin
    len_fix = (in_item.unit_length == '0) ? LenW'(1) : in_item.unit_length;
    if (CmpW'(len_fix) > CmpW'(MAX_UNIT_BYTES)) begin
      len_fix = LenW'(MAX_UNIT_BYTES);
    end
    len_eff  = in_item.unit_start ? len_fix : unit_bytes_left;
    ch_eff   = in_item.unit_start ? in_item.channel : current_channel;
    open_eff = in_item.unit_start | unit_open;
    need_hdr = in_item.unit_start | (packet_bytes_left == '0);
    use_pcr  = in_item.unit_start & in_item.pcr_present;
    room     = use_pcr ? PcrRoom : PktPayload;
    data_cnt = (len_eff < LenW'(room)) ? len_eff[7:0] : room;
    pbl_next = (need_hdr ? data_cnt : packet_bytes_left) - 8'd1;
    ubl_next = len_eff - LenW'(1);
  end

  assign fire = in_valid & ~full;
  assign push = fire & open_eff;

  always_comb begin
    job.data_byte = in_item.data_byte;
    job.pkt_end   = (pbl_next == '0);
    job.hdr       = need_hdr;
    job.first     = in_item.unit_start;
    job.pcr       = use_pcr;
    job.pcr_base  = in_item.pcr_base;
    job.pid       = pid_reg[ch_eff];
    job.cc        = cc_reg[ch_eff];
    job.adapt     = PktPayload - data_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_reg[REG_PID_PAT]   <= PidW'(0);
      pid_reg[REG_PID_PMT]   <= PidW'(32);
      pid_reg[REG_PID_VIDEO] <= PidW'(33);
      pid_reg[REG_PID_AUDIO] <= PidW'(34);
    end else if (cfg.we) begin
      pid_reg[cfg.index] <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cc_reg[i] <= '0;
      end
      unit_bytes_left   <= '0;
      packet_bytes_left <= '0;
      current_channel   <= '0;
      unit_open         <= 1'b0;
    end else if (push) begin
      if (need_hdr) begin
        cc_reg[ch_eff] <= cc_reg[ch_eff] + CcW'(1);
      end
      unit_bytes_left   <= ubl_next;
      packet_bytes_left <= pbl_next;
      current_channel   <= ch_eff;
      unit_open         <= (ubl_next != '0);
    end
  end

endmodule

/* design/ts_pkt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkt_queue
// Short job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ts_pkt_queue
  import ts_pkt_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CntW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* design/ts_pkt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkt_back
// Expands the head job into any header, adaptation field and stuffing run,
// then its data byte, one result per unstalled cycle into an output register.
// ----------------------------------------------------------------------------
module ts_pkt_back
  import ts_pkt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  job_t    head,
  output logic    pop,
  output logic    m_valid,
  output result_t m_result,
  input  logic    m_ready
);

  step_t      step;
  step_t      step_next;
  step_t      eff_step;
  logic       fresh;
  logic       emit;
  logic [7:0] stuff;
  result_t    res;

  // fresh: head job not started yet; its first step follows from hdr
  assign eff_step = fresh ? (head.hdr ? STEP_SYNC : STEP_DATA) : step;
  assign emit     = q_valid & (~m_valid | m_ready);
  assign pop      = emit & (eff_step == STEP_DATA);
  assign stuff    = head.adapt - (head.pcr ? AdaptPcr : AdaptNoPcr);

  always_comb begin
    unique case (eff_step)
      STEP_SYNC:      step_next = STEP_PID_HI;
      STEP_PID_HI:    step_next = STEP_PID_LO;
      STEP_PID_LO:    step_next = STEP_CTRL;
      STEP_CTRL:      step_next = (head.adapt != '0) ? STEP_ADAPT_LEN : STEP_DATA;
      STEP_ADAPT_LEN: step_next = (head.adapt > 8'd1) ? STEP_FLAGS : STEP_DATA;
      STEP_FLAGS: begin
        if (head.pcr) begin
          step_next = STEP_PCR0;
        end else begin
          step_next = (stuff != '0) ? STEP_STUFF : STEP_DATA;
        end
      end
      STEP_PCR0:      step_next = STEP_PCR1;
      STEP_PCR1:      step_next = STEP_PCR2;
      STEP_PCR2:      step_next = STEP_PCR3;
      STEP_PCR3:      step_next = STEP_PCR4;
      STEP_PCR4:      step_next = STEP_PCR5;
      STEP_PCR5:      step_next = (stuff != '0) ? STEP_STUFF : STEP_DATA;
      STEP_STUFF:     step_next = STEP_DATA;
      STEP_DATA:      step_next = STEP_DATA;
      default:        step_next = STEP_DATA;
    endcase
  end

  always_comb begin
    res.out_byte     = head.data_byte;
    res.repeat_count = 8'd1;
    res.packet_end   = 1'b0;
    res.last_of_run  = 1'b0;
    unique case (eff_step)
      STEP_SYNC:      res.out_byte = SyncByte;
      STEP_PID_HI:    res.out_byte = {1'b0, head.first, 1'b0, head.pid[12:8]};
      STEP_PID_LO:    res.out_byte = head.pid[7:0];
      STEP_CTRL: begin
        res.out_byte = {((head.adapt != '0) ? CtrlAdapt : CtrlPayload), head.cc};
      end
      STEP_ADAPT_LEN: res.out_byte = head.adapt - 8'd1;
      STEP_FLAGS:     res.out_byte = head.pcr ? PcrFlags : NoFlags;
      STEP_PCR0:      res.out_byte = head.pcr_base[32:25];
      STEP_PCR1:      res.out_byte = head.pcr_base[24:17];
      STEP_PCR2:      res.out_byte = head.pcr_base[16:9];
      STEP_PCR3:      res.out_byte = head.pcr_base[8:1];
      STEP_PCR4:      res.out_byte = {head.pcr_base[0], PcrTail};
      STEP_PCR5:      res.out_byte = PcrExt;
      STEP_STUFF: begin
        res.out_byte     = StuffByte;
        res.repeat_count = stuff;
      end
      STEP_DATA: begin
        res.packet_end  = head.pkt_end;
        res.last_of_run = 1'b1;
      end
      default: res.out_byte = head.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_DATA;
      fresh <= 1'b1;
    end else if (emit) begin
      step  <= step_next;
      fresh <= (eff_step == STEP_DATA);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_result <= res;
    end
  end

endmodule

/* design/ts_packetizer_core.sv */
`timescale 1ns / 1ps
`include "ts_packetizer_core_defines.svh"
// ----------------------------------------------------------------------------
// ts_packetizer_core
// Cuts byte units into 188-byte MPEG-2 transport packets.
// ----------------------------------------------------------------------------
// Feed one payload byte per beat; the first beat of a unit carries its length,
// channel and optional PCR. The slave side takes a beat every cycle while the
// job queue (QUEUE_DEPTH entries) has room. Each beat taken while a unit is
// open becomes one job; the back end plays a job out at one result per cycle
// while m_axis_tready does not stall it: one result for a plain data byte; for
// a byte that opens a packet, the 4-byte header, optional adaptation field
// with PCR, a single result for the whole 0xFF stuffing run given as a repeat
// count, then the data byte. Sustained input rate is one beat per cycle apart
// from the header results of the back end and output stalls. Bytes arriving
// with no unit open are taken and dropped. PID registers are written through
// cfg_we / cfg_index / cfg_data and must only change while the block is idle.
// ----------------------------------------------------------------------------
module ts_packetizer_core
  import ts_pkt_pkg::*;
#(
  parameter int unsigned MAX_UNIT_BYTES = MaxUnitBytesDef,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_byte[7:0], unit_length[28:8],
                                      // pcr_base[61:29], zero[63:62]
  input  logic [3:0]  s_axis_tuser,   // unit_start[0], channel[2:1],
                                      // pcr_present[3]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], repeat_count[15:8]
  output logic [0:0]  m_axis_tuser,   // packet_end[0]
  output logic        m_axis_tlast    // last_of_run
);

  cfg_wr_t  cfg;
  in_item_t in_item;
  job_t     push_job;
  job_t     head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  logic     q_valid;
  result_t  m_result;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_data;

  assign in_item.data_byte   = s_axis_tdata[7:0];
  assign in_item.unit_length = s_axis_tdata[28:8];
  assign in_item.pcr_base    = s_axis_tdata[61:29];
  assign in_item.unit_start  = s_axis_tuser[0];
  assign in_item.channel     = s_axis_tuser[2:1];
  assign in_item.pcr_present = s_axis_tuser[3];

  assign s_axis_tready = ~q_full;
  assign q_valid       = ~q_empty;

  // front end: unit/packet tracking and header decisions
  ts_pkt_front #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_item  (in_item),
    .full     (q_full),
    .push     (push),
    .job      (push_job)
  );

  ts_pkt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: result sequencer and output register
  ts_pkt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_valid  (m_axis_tvalid),
    .m_result (m_result),
    .m_ready  (m_axis_tready)
  );

  assign m_axis_tdata    = {m_result.repeat_count, m_result.out_byte};
  assign m_axis_tuser[0] = m_result.packet_end;
  assign m_axis_tlast    = m_result.last_of_run;

  // packet end only ever lands on the data byte, which closes the beat
  `TSP_ASSERT_NOW(a_pend_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "packet end not on last result")
  // runs longer than one byte are stuffing only
  `TSP_ASSERT_NOW(a_run_is_stuff, m_axis_tvalid && m_axis_tdata[15:8] != 8'd1, m_axis_tdata[7:0] == 8'hFF && m_axis_tdata[15:8] != 8'd0, "bad repeat run")
  // data byte always goes out singly
  `TSP_ASSERT_NOW(a_last_single, m_axis_tvalid && m_axis_tlast, m_axis_tdata[15:8] == 8'd1, "data byte repeated")
  // a pending job with an empty output register is shown next cycle
  `TSP_ASSERT_NEXT(a_out_fill, q_valid && !m_axis_tvalid, m_axis_tvalid, "output register not refilled")

endmodule
